@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each macro names a labeled concurrent assertion sampled on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed");

`endif

@@ rtl/mhld_pkg.sv @@
// ----------------------------------------------------------------------------
// Magic header deframer package
// Shared types, register indexes and constants of the length-prefixed
// frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mhld_pkg;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_TYPE    = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_WANTED_TYPE      = 2'd0;
   localparam csr_index_type CSR_ACCEPT_ANY_TYPE  = 2'd1;
   localparam csr_index_type CSR_MAX_FRAME_LENGTH = 2'd2;

   localparam logic [7:0]  WANTED_TYPE_RESET      = 8'd0;
   localparam logic        ACCEPT_ANY_TYPE_RESET  = 1'b1;
   localparam logic [30:0] MAX_FRAME_LENGTH_RESET = 31'd65536;

   localparam logic [31:0] FRAME_OVERHEAD = 32'd9;
   localparam logic [1:0]  HEADER_LAST    = 2'd3;
   localparam logic [1:0]  LENGTH_LAST    = 2'd3;

   typedef struct packed {
      logic [7:0]  wanted_type;
      logic        accept_any_type;
      logic [30:0] max_frame_length;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic [7:0] frame_kind;
      logic       first_of_frame;
      logic       last_of_frame;
   } rsp_type;

   function automatic logic [7:0] header_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = 8'h54;
         2'd1:    value = 8'h61;
         2'd2:    value = 8'h6D;
         2'd3:    value = 8'h69;
         default: value = 8'h54;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mhld_parser.sv @@
// ----------------------------------------------------------------------------
// Magic header deframer parser
// Frame state machine: header hunt, length gather, type byte and payload
// count, updated once for each byte that steps it.
// ----------------------------------------------------------------------------
`default_nettype none

module mhld_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  mhld_pkg::cfg_type cfg,
   output mhld_pkg::rsp_type result
);
   import mhld_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [1:0]  len_cnt_ff, len_cnt_in;
   logic [23:0] len_lo_ff, len_lo_in;
   logic [30:0] left_ff, left_in;
   logic [7:0]  type_ff, type_in;
   logic        pass_ff, pass_in;
   logic        first_ff, first_in;

   logic [31:0] len_full;
   logic [30:0] len_payload;
   logic        len_bad;
   logic        hdr_hit;
   logic        left_last;

   assign len_full    = {rx_byte, len_lo_ff};
   assign len_payload = len_full[30:0] - FRAME_OVERHEAD[30:0];
   assign len_bad     = (len_full < FRAME_OVERHEAD) || (len_full > {1'b0, cfg.max_frame_length});
   assign hdr_hit     = (rx_byte == header_byte(hdr_cnt_ff));
   assign left_last   = (left_ff == 31'd1);

   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_HUNT: begin
               if (hdr_hit && (hdr_cnt_ff == HEADER_LAST)) begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (len_cnt_ff == LENGTH_LAST) begin
                  phase_in = len_bad ? PH_HUNT : PH_TYPE;
               end
            end
            PH_TYPE: begin
               phase_in = (left_ff == 31'd0) ? PH_HUNT : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (left_last) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      len_cnt_in = len_cnt_ff;
      len_lo_in  = len_lo_ff;
      left_in    = left_ff;
      type_in    = type_ff;
      pass_in    = pass_ff;
      first_in   = first_ff;
      if (step) begin
         case (phase_ff)
            PH_HUNT: begin
               if (hdr_hit) begin
                  hdr_cnt_in = (hdr_cnt_ff == HEADER_LAST) ? 2'd0 : hdr_cnt_ff + 2'd1;
               end else begin
                  hdr_cnt_in = {1'b0, rx_byte == header_byte(2'd0)};
               end
            end
            PH_LENGTH: begin
               len_cnt_in = len_cnt_ff + 2'd1;
               case (len_cnt_ff)
                  2'd0:    len_lo_in[7:0]   = rx_byte;
                  2'd1:    len_lo_in[15:8]  = rx_byte;
                  2'd2:    len_lo_in[23:16] = rx_byte;
                  default: len_lo_in        = len_lo_ff;
               endcase
               if ((len_cnt_ff == LENGTH_LAST) && !len_bad) begin
                  left_in = len_payload;
               end
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               pass_in  = cfg.accept_any_type || (rx_byte == cfg.wanted_type);
               first_in = 1'b1;
            end
            PH_PAYLOAD: begin
               left_in  = left_ff - 31'd1;
               first_in = 1'b0;
            end
            default: begin
               hdr_cnt_in = 2'd0;
            end
         endcase
      end
   end

   always_comb begin
      result.valid          = step && (phase_ff == PH_PAYLOAD) && pass_ff;
      result.payload_byte   = rx_byte;
      result.frame_kind     = type_ff;
      result.first_of_frame = first_ff;
      result.last_of_frame  = left_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         hdr_cnt_ff <= 2'd0;
         len_cnt_ff <= 2'd0;
         left_ff    <= 31'd0;
         pass_ff    <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         len_cnt_ff <= len_cnt_in;
         left_ff    <= left_in;
         pass_ff    <= pass_in;
         first_ff   <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      len_lo_ff <= len_lo_in;
      type_ff   <= type_in;
   end

endmodule

`default_nettype wire

@@ rtl/magic_header_length_deframer_top.sv @@
// Path: an accepted byte is held in the input register, the parser acts on it
// combinationally, and its payload beat is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates once per byte.
// A stalled result holds in the output register while one more byte waits in
// the input register, after which req_ready drops until rsp_ready returns.
// Reset: synchronous, clears the frame state and restores the register defaults.
// ----------------------------------------------------------------------------
// Magic header length-prefixed frame deframer
// Hunts for the four-byte header, reads the length and type, and passes on
// the payload bytes of accepted frames with first and last marks.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_header_length_deframer_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_payload_byte,
   output logic [7:0]              rsp_frame_kind,
   output logic                    rsp_first_of_frame,
   output logic                    rsp_last_of_frame,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  mhld_pkg::csr_index_type csr_index,
   input  logic [30:0]             csr_wdata
);
   import mhld_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       step;
   rsp_type    result;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic [7:0] rsp_kind_ff;
   logic       rsp_first_ff;
   logic       rsp_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_type      <= WANTED_TYPE_RESET;
         cfg_ff.accept_any_type  <= ACCEPT_ANY_TYPE_RESET;
         cfg_ff.max_frame_length <= MAX_FRAME_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WANTED_TYPE:      cfg_ff.wanted_type      <= csr_wdata[7:0];
            CSR_ACCEPT_ANY_TYPE:  cfg_ff.accept_any_type  <= csr_wdata[0];
            CSR_MAX_FRAME_LENGTH: cfg_ff.max_frame_length <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mhld_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         rsp_byte_ff  <= result.payload_byte;
         rsp_kind_ff  <= result.frame_kind;
         rsp_first_ff <= result.first_of_frame;
         rsp_last_ff  <= result.last_of_frame;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_frame_kind     = rsp_kind_ff;
   assign rsp_first_of_frame = rsp_first_ff;
   assign rsp_last_of_frame  = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/mhld_checker.sv @@
// ----------------------------------------------------------------------------
// Magic header deframer checker
// Port-level assertions on the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mhld_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_ready,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire [7:0]              rsp_payload_byte,
   input wire [7:0]              rsp_frame_kind,
   input wire                    rsp_first_of_frame,
   input wire                    rsp_last_of_frame
);

   // A beat that is not taken stays on the port unchanged.
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_frame_kind) && $stable(rsp_first_of_frame) && $stable(rsp_last_of_frame))

   // Reset leaves no result beat pending.
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

   // With the output register empty, the input side never stalls.
   `ASSERT_CLK(a_ready_when_empty, !rsp_valid |-> req_ready)

   // A beat that does not close its frame is never followed by a frame start.
   `ASSERT_CLK(a_no_early_first, rsp_valid && rsp_ready && !rsp_last_of_frame |=> !(rsp_valid && rsp_first_of_frame))

endmodule

bind magic_header_length_deframer_top mhld_checker u_mhld_checker (.*);

`default_nettype wire
